FILE: rtl/core/hsbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsbp_pkg
// Shared types and constants for the Huffman stream bit packer.
// ----------------------------------------------------------------------------
package hsbp_pkg;

	// Command codes of an input request
	localparam logic [1:0] CmdLoad   = 2'd0;
	localparam logic [1:0] CmdEncode = 2'd1;
	localparam logic [1:0] CmdFlush  = 2'd2;

	localparam int LenW  = 6;   // code length field
	localparam int CodeW = 32;  // code bits field
	localparam int ByteW = 8;
	localparam int WorkW = 39;  // seven pending bits plus the longest code
	localparam int CntW  = 6;   // holds 0 .. WorkW

	// Request handed from the table lookup to the packer
	typedef struct packed {
		logic [1:0]       cmd;
		logic [LenW-1:0]  len;
		logic [CodeW-1:0] bits;
	} hsbp_req_t;

endpackage

FILE: rtl/core/hsbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsbp_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/hsbp_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsbp_packer
// Bit buffer and byte emitter: absorbs looked-up codes, emits packed bytes
// one per cycle while out_ready holds, through an output register, pads on flush.
// ----------------------------------------------------------------------------
module hsbp_packer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  hsbp_pkg::hsbp_req_t          req,
	output logic                         req_take,
	input  logic [hsbp_pkg::ByteW-1:0]   offset,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hsbp_pkg::ByteW-1:0]   out_byte,
	output logic                         last
);
	import hsbp_pkg::*;

	logic [WorkW-1:0] work_q;
	logic [CntW-1:0]  cnt_q;
	logic             out_valid_q;
	logic [ByteW-1:0] out_byte_q;
	logic             last_q;

	logic             out_free;
	logic             emit_now;
	logic [CntW-1:0]  base_cnt;
	logic [6:0]       base_bits;
	logic [WorkW-1:0] acc;
	logic [WorkW-1:0] emit_shift;
	logic [14:0]      pad_shift;
	logic             flush_emit;

	// Output register is free when empty or being drained
	assign out_free = !out_valid_q || out_ready;
	assign emit_now = out_free && (cnt_q >= CntW'(8));
	assign base_cnt = emit_now ? (cnt_q - CntW'(8)) : cnt_q;

	// Keep only the bits still pending after this cycle's emit
	assign base_bits = work_q[6:0] & ~(7'h7f << base_cnt[2:0]);
	assign acc       = (WorkW'(base_bits) << req.len) | WorkW'(req.bits);

	// Next full byte sits just below the valid count; flush pads with zeros
	assign emit_shift = work_q >> (cnt_q - CntW'(8));
	assign pad_shift  = {work_q[6:0], 8'h00} >> cnt_q[2:0];

	// Decide whether the waiting request can be taken this cycle
	always_comb begin
		req_take   = 1'b0;
		flush_emit = 1'b0;
		if (req_valid) begin
			case (req.cmd)
				CmdEncode: begin
					req_take = (cnt_q < CntW'(8)) || (emit_now && cnt_q < CntW'(16));
				end
				CmdFlush: begin
					req_take   = (cnt_q < CntW'(8)) && (cnt_q == '0 || out_free);
					flush_emit = req_take && cnt_q != '0;
				end
				default: begin
					req_take = 1'b1;
				end
			endcase
		end
	end

	// Bit buffer: drop emitted bytes, append new codes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			work_q <= '0;
		end else if (req_take && req.cmd == CmdEncode) begin
			work_q <= acc;
			cnt_q  <= base_cnt + req.len;
		end else if (flush_emit) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base_cnt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_now || flush_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			out_byte_q <= emit_shift[7:0] + offset;
			last_q     <= cnt_q < CntW'(16);
		end else if (flush_emit) begin
			out_byte_q <= pad_shift[7:0] + offset;
			last_q     <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	// Buffer never holds more than seven pending bits plus one code
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(WorkW))
		else $error("bit buffer count out of range");

	// A byte that is not an item's last leaves at least a full byte behind
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit_now && cnt_q >= CntW'(16) |=> cnt_q >= CntW'(8))
		else $error("byte marked not last but buffer ran short");

	// A flush that emits leaves the buffer empty
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		flush_emit |=> cnt_q == '0 && out_valid_q && last_q)
		else $error("flush did not empty the buffer");

	// Nothing is absorbed while a full byte is still waiting behind this one
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && req.cmd == CmdEncode |-> base_cnt < CntW'(8))
		else $error("code absorbed over a full byte");

endmodule

FILE: rtl/core/huffman_stream_bit_packer.sv
`timescale 1ns / 1ps
// An encode's first byte is registered at the output after the lookup stage and bit buffer.
// Throughput: one request per cycle while each adds under eight bits and out_ready holds;
// the packer emits one byte per ready cycle, and two or more pending bytes stall the input.
// Reset clears the per-entry valid bits at once, so the whole code table reads as
// zero length with no clearing pass; the bit buffer empties and the offset is 48.
// ----------------------------------------------------------------------------
// huffman_stream_bit_packer
// Code table held in a synchronous RAM, looked up per symbol and fed to a
// bit packer that emits offset-adjusted bytes, first bit in the MSB.
// ----------------------------------------------------------------------------
module huffman_stream_bit_packer #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   command,
	input  logic [7:0]                   symbol,
	input  logic [hsbp_pkg::LenW-1:0]    code_length,
	input  logic [hsbp_pkg::CodeW-1:0]   code_bits,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hsbp_pkg::ByteW-1:0]   out_byte,
	output logic                         last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hsbp_pkg::ByteW-1:0]   cfg_output_offset
);
	import hsbp_pkg::*;

	localparam int CapLen = (MAX_CODE_LEN < CodeW) ? MAX_CODE_LEN : CodeW;
	localparam int EntW   = LenW + CapLen;

	logic [ByteW-1:0]  offset_q;
	logic [255:0]      valid_q;
	logic              accept;
	logic              load_we;
	logic              rd_en;
	logic [LenW-1:0]   load_len;
	logic [CapLen-1:0] load_bits;
	logic [EntW-1:0]   rdata;
	logic              req_valid_s1;
	logic [1:0]        cmd_s1;
	logic              hit_s1;
	logic              req_take;
	hsbp_req_t         req;

	// Output offset register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= ByteW'(48);
		end else if (cfg_valid) begin
			offset_q <= cfg_output_offset;
		end
	end

	// Input handshake: loads and unused commands finish on acceptance, encodes and flushes enter stage 1
	assign in_ready = !req_valid_s1 || req_take;
	assign accept   = in_valid && in_ready;
	assign load_we  = accept && command == CmdLoad;
	assign rd_en    = accept && command == CmdEncode;

	// Saturate the length and drop bits above it
	assign load_len  = (code_length > LenW'(CapLen)) ? LenW'(CapLen) : code_length;
	assign load_bits = code_bits[CapLen-1:0] & ~({CapLen{1'b1}} << load_len);

	hsbp_ram #(
		.Width (EntW),
		.Depth (256)
	) u_table (
		.clk   (clk),
		.we    (load_we),
		.waddr (symbol),
		.wdata ({load_len, load_bits}),
		.re    (rd_en),
		.raddr (symbol),
		.rdata (rdata)
	);

	// Per-entry valid bits: an unwritten entry reads as zero length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (load_we) begin
			valid_q[symbol] <= 1'b1;
		end
	end

	// Lookup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (accept) begin
			req_valid_s1 <= command == CmdEncode || command == CmdFlush;
		end else if (req_take) begin
			req_valid_s1 <= 1'b0;
		end
	end

	// Only an encode uses the read data; anything else sees no code
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
			hit_s1 <= command == CmdEncode && valid_q[symbol];
		end
	end

	// Hand the looked-up code to the packer
	always_comb begin
		req.cmd  = cmd_s1;
		req.len  = hit_s1 ? rdata[EntW-1 -: LenW] : '0;
		req.bits = hit_s1 ? CodeW'(rdata[CapLen-1:0]) : '0;
	end

	hsbp_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid_s1),
		.req       (req),
		.req_take  (req_take),
		.offset    (offset_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	// A load marks its entry valid
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_we |=> valid_q[$past(symbol)])
		else $error("loaded table entry not marked valid");

	// Loads never occupy the lookup stage
	a_load_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		load_we |=> !req_valid_s1)
		else $error("load request entered the lookup stage");

	// A stored length never exceeds the cap
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 |-> req.len <= LenW'(CapLen))
		else $error("code length above cap");

endmodule

FILE: bench/hsbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsbp_checker
// Watches the request, output and offset channels of the bit packer. Each
// accepted request is run through a local copy of the code table and bit
// buffer, and the bytes it should produce are queued. Each accepted output
// byte is compared with the oldest queued byte. Mismatches are counted.
// ----------------------------------------------------------------------------
module hsbp_checker #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [1:0]                   command,
	input  logic [7:0]                   symbol,
	input  logic [hsbp_pkg::LenW-1:0]    code_length,
	input  logic [hsbp_pkg::CodeW-1:0]   code_bits,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [hsbp_pkg::ByteW-1:0]   out_byte,
	input  logic                         last,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [hsbp_pkg::ByteW-1:0]   cfg_output_offset,
	output int                           mismatch_count,
	output int                           bytes_outstanding
);
	import hsbp_pkg::*;

	localparam int LenCap = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

	typedef struct {
		logic [ByteW-1:0] value;
		logic             last;
	} packed_byte_t;

	// Local copy of the code table, bit buffer and offset
	logic [LenW-1:0]  length_tab [256];
	logic [CodeW-1:0] bits_tab [256];
	logic [6:0]       held_bits;
	logic [2:0]       held_count;
	logic [ByteW-1:0] offset;

	packed_byte_t expected_bytes [$];
	int           errors;

	function automatic logic [63:0] low_mask(input int n);
		return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
	endfunction

	// Queue one byte with the current offset applied
	task automatic queue_byte(input logic [7:0] raw, input logic is_last);
		packed_byte_t item;
		item.value = raw + offset;
		item.last  = is_last;
		expected_bytes.push_back(item);
	endtask

	// Apply one accepted request to the local state and queue its bytes
	task automatic pack_request(input logic [1:0] cmd, input logic [7:0] sym,
			input logic [LenW-1:0] len, input logic [CodeW-1:0] code);
		int          clen;
		int          total;
		logic [63:0] acc;
		logic [7:0]  tail;
		case (cmd)
			CmdLoad: begin
				// Saturate overlong lengths, drop bits above the stored length
				clen = (int'(len) > LenCap) ? LenCap : int'(len);
				length_tab[sym] = clen[LenW-1:0];
				bits_tab[sym] = CodeW'(64'(code) & low_mask(clen));
			end
			CmdEncode: begin
				clen = int'(length_tab[sym]);
				if (clen > LenCap)
					clen = LenCap;
				// A symbol with no code leaves the buffer alone
				if (clen != 0) begin
					total = int'(held_count) + clen;
					acc = (64'(held_bits) << clen) | (64'(bits_tab[sym]) & low_mask(clen));
					acc = acc & low_mask(total);
					while (total >= 8) begin
						total -= 8;
						queue_byte(acc[total +: 8], total < 8);
					end
					acc = acc & low_mask(total);
					held_count = total[2:0];
					held_bits = acc[6:0];
				end
			end
			CmdFlush: begin
				// Pad a partial byte with zeros; an empty buffer gives nothing
				if (held_count != 3'd0) begin
					tail = {1'b0, held_bits} << (4'd8 - {1'b0, held_count});
					queue_byte(tail, 1'b1);
					held_bits = '0;
					held_count = '0;
				end
			end
			default: begin
				// Unused command: ignore
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		packed_byte_t want;
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) begin
				length_tab[i] = '0;
				bits_tab[i] = '0;
			end
			held_bits = '0;
			held_count = '0;
			offset = 8'd48;
			expected_bytes.delete();
			errors = 0;
			mismatch_count <= 0;
			bytes_outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				offset = cfg_output_offset;
			if (in_valid && in_ready)
				pack_request(command, symbol, code_length, code_bits);
			// Compare each accepted byte with the oldest queued one
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected output: out_byte %0d, last %0b", out_byte, last);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.value) begin
						$error("out_byte: expected %0d, actual %0d", want.value, out_byte);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, last);
						errors++;
					end
				end
			end
			mismatch_count <= errors;
			bytes_outstanding <= expected_bytes.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the bit packer with code table loads, encodes and flushes over
// several output offsets, with random idling on both sides, a long output
// stall and a drained pause. The checker beside the block does the compare.
// ----------------------------------------------------------------------------
module tb_top;
	import hsbp_pkg::*;

	localparam int MaxCodeLen     = 32;
	localparam int LongHold       = 300;
	localparam int SettleCycles   = 8;
	localparam int StallLimit     = 2000;
	localparam int RandomPerPhase = 60;

	localparam logic [1:0] CmdUnused = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        command = CmdLoad;
	logic [7:0]        symbol = '0;
	logic [LenW-1:0]   code_length = '0;
	logic [CodeW-1:0]  code_bits = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [ByteW-1:0]  out_byte;
	logic              last;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ByteW-1:0]  cfg_output_offset = '0;

	logic              quiet_end = 1'b0;
	logic              hold_rx = 1'b0;
	int                mismatch_count;
	int                bytes_outstanding;
	int                stall_cycles = 0;
	logic [7:0]        coded_syms [$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	huffman_stream_bit_packer #(
		.MAX_CODE_LEN(MaxCodeLen)
	) i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.command           (command),
		.symbol            (symbol),
		.code_length       (code_length),
		.code_bits         (code_bits),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_byte          (out_byte),
		.last              (last),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_output_offset (cfg_output_offset)
	);

	hsbp_checker #(
		.MAX_CODE_LEN(MaxCodeLen)
	) i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.command           (command),
		.symbol            (symbol),
		.code_length       (code_length),
		.code_bits         (code_bits),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_byte          (out_byte),
		.last              (last),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_output_offset (cfg_output_offset),
		.mismatch_count    (mismatch_count),
		.bytes_outstanding (bytes_outstanding)
	);

	// End the run when no channel has moved for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= StallLimit) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Output side: random stalls, runs of full rate, one long hold-off
	initial begin : receiver
		logic held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
				out_ready <= 1'b1;
			end else if (quiet_end) begin
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// Offer one request, with an occasional idle burst first, and hold it until taken
	task automatic send_request(input logic [1:0] cmd, input logic [7:0] sym,
			input logic [LenW-1:0] len, input logic [CodeW-1:0] bits);
		if (!quiet_end && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		symbol <= sym;
		code_length <= len;
		code_bits <= bits;
		do @(posedge clk); while (!in_ready);
	endtask

	// Load a table entry and remember symbols that now carry a code
	task automatic load_code(input logic [7:0] sym, input logic [LenW-1:0] len,
			input logic [CodeW-1:0] bits);
		send_request(CmdLoad, sym, len, bits);
		if (len != '0)
			coded_syms.push_back(sym);
	endtask

	// Drop valid and wait until every queued byte has come out
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (bytes_outstanding != 0);
	endtask

	// Write the offset once the block has drained and settled
	task automatic set_offset(input logic [ByteW-1:0] value);
		wait_for_drain();
		repeat (SettleCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_output_offset <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly loads and encodes of coded symbols, with flushes and noise
	task automatic random_request();
		int          pick;
		logic [7:0]  sym;
		logic [5:0]  len;
		pick = $urandom_range(0, 99);
		if (pick < 20 || coded_syms.size() == 0) begin
			sym = 8'($urandom_range(0, 255));
			len = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) :
				6'($urandom_range(1, 12));
			load_code(sym, len, $urandom());
		end else if (pick < 85) begin
			sym = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
			send_request(CmdEncode, sym, 6'($urandom_range(0, 63)), $urandom());
		end else if (pick < 92) begin
			send_request(CmdFlush, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
				$urandom());
		end else if (pick < 96) begin
			send_request(CmdUnused, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
				$urandom());
		end else begin
			send_request(CmdEncode, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
				$urandom());
		end
	endtask

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, empty buffer and the unused command give nothing
		send_request(CmdEncode, 8'h00, '0, '0);
		send_request(CmdFlush, 8'h00, '0, '0);
		send_request(CmdUnused, 8'hFF, '1, '1);
		// Extremes of length, overlong lengths and stray upper bits
		load_code(8'h00, 6'd1, 32'hFFFF_FFFF);
		load_code(8'hFF, 6'd32, 32'hFFFF_FFFF);
		load_code(8'h55, 6'd63, 32'hA5A5_A5A5);
		load_code(8'hAA, 6'd7, 32'hDEAD_BE55);
		load_code(8'h01, 6'd8, 32'h0000_005A);
		load_code(8'h02, 6'd33, 32'h1234_5678);
		send_request(CmdEncode, 8'h00, '0, '0);
		send_request(CmdEncode, 8'hFF, '0, '0);
		send_request(CmdEncode, 8'h01, '0, '0);
		send_request(CmdEncode, 8'hAA, '0, '0);
		send_request(CmdEncode, 8'h55, '0, '0);
		send_request(CmdEncode, 8'h02, '0, '0);
		// Seven bits pending plus the longest code, then pad
		send_request(CmdEncode, 8'hAA, '0, '0);
		send_request(CmdEncode, 8'hFF, '0, '0);
		send_request(CmdFlush, 8'h00, '0, '0);
		// Encode straight after loading the same entry
		load_code(8'h03, 6'd3, 32'h0000_0005);
		send_request(CmdEncode, 8'h03, '0, '0);
		// A code cleared to zero length gives nothing
		load_code(8'h01, 6'd0, 32'hFFFF_FFFF);
		send_request(CmdEncode, 8'h01, '0, '0);
		send_request(CmdFlush, 8'h00, '0, '0);
		load_code(8'h80, 6'd20, 32'h000F_0F0F);

		repeat (RandomPerPhase) random_request();

		// Minimum offset, with the output held off while requests pile up
		set_offset(8'd0);
		repeat (10) random_request();
		hold_rx <= 1'b1;
		repeat (RandomPerPhase - 10) random_request();

		// Maximum offset, with a drained pause half way
		set_offset(8'd255);
		repeat (RandomPerPhase / 2) random_request();
		wait_for_drain();
		repeat (RandomPerPhase / 2) random_request();

		set_offset(8'($urandom_range(1, 254)));
		repeat (RandomPerPhase) random_request();

		// Last stretch at full rate on both sides
		set_offset(8'($urandom_range(0, 255)));
		quiet_end <= 1'b1;
		repeat (RandomPerPhase) random_request();

		wait_for_drain();
		repeat (SettleCycles * 2) @(posedge clk);
		if (mismatch_count == 0 && bytes_outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/hsbp_pkg.sv
rtl/core/hsbp_ram.sv
rtl/core/hsbp_packer.sv
rtl/core/huffman_stream_bit_packer.sv
bench/hsbp_checker.sv
bench/tb_top.sv
